// ===== design/sfcs_pkg.sv =====
// Shared types, codes and the sequence ROM of the serial NOR flash command sequencer.
`timescale 1ns / 1ps

package sfcs_pkg;

  // Request function codes
  localparam logic [2:0] FN_WRITE  = 3'd0;
  localparam logic [2:0] FN_DATA   = 3'd1;
  localparam logic [2:0] FN_READ   = 3'd2;
  localparam logic [2:0] FN_RX     = 3'd3;
  localparam logic [2:0] FN_SECTOR = 3'd4;
  localparam logic [2:0] FN_CHIP   = 3'd5;

  // Flash opcodes
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_WRDI   = 8'h04;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_SECTOR = 8'h20;
  localparam logic [7:0] OP_CHIP   = 8'h60;
  localparam logic [7:0] OP_RDSR1  = 8'h05;
  localparam logic [7:0] OP_PROG   = 8'h02;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 25;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_MIN   = 5'd8;
  localparam logic [CAP_W-1:0] CAP_MAX   = 5'd24;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd24;

  // Link actions
  typedef enum logic [2:0] {
    ACT_SELECT  = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RECV    = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_DONE    = 3'd5,
    ACT_REJECT  = 3'd6
  } act_t;

  // Where the link byte of one step comes from
  typedef enum logic [2:0] {
    SRC_CONST   = 3'd0,
    SRC_ADDR_HI = 3'd1,
    SRC_ADDR_MD = 3'd2,
    SRC_ADDR_LO = 3'd3,
    SRC_DATA    = 3'd4
  } src_t;

  // Front phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_WDATA = 4'b0010,
    PH_POLL  = 4'b0100,
    PH_READ  = 4'b1000
  } phase_t;

  // Sequence ROM entry points
  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_REJECT     = 6'd0;
  localparam pc_t PC_DONE       = 6'd1;
  localparam pc_t PC_REL_DONE   = 6'd2;
  localparam pc_t PC_WDATA_MID  = 6'd3;
  localparam pc_t PC_WDATA_END  = 6'd4;
  localparam pc_t PC_TAIL       = 6'd5;
  localparam pc_t PC_WRDI       = 6'd6;
  localparam pc_t PC_POLL_AGAIN = 6'd8;
  localparam pc_t PC_POLL       = 6'd9;
  localparam pc_t PC_RD_MID     = 6'd12;
  localparam pc_t PC_RD_END     = 6'd14;
  localparam pc_t PC_NEXT_CHUNK = 6'd15;
  localparam pc_t PC_CHUNK      = 6'd16;
  localparam pc_t PC_READ       = 6'd24;
  localparam pc_t PC_READ_EMPTY = 6'd30;
  localparam pc_t PC_SECTOR     = 6'd35;
  localparam pc_t PC_CHIP       = 6'd43;

  // One job handed from front to back
  typedef struct packed {
    pc_t              pc;
    logic [ADDR_W-1:0] addr;
    logic [7:0]       data;
  } job_t;

  // One step of a sequence
  typedef struct packed {
    act_t       action;
    src_t       src;
    logic [7:0] cbyte;
    logic       last;
    pc_t        next;
  } uop_t;

  function automatic uop_t mk(act_t a, src_t s, logic [7:0] b, logic l, pc_t n);
    uop_t u;
    u.action = a;
    u.src    = s;
    u.cbyte  = b;
    u.last   = l;
    u.next   = n;
    return u;
  endfunction

  // Sequence ROM: each entry is one result; next links steps into sequences
  function automatic uop_t uop_rom(pc_t pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(ACT_REJECT,  SRC_CONST,   8'h00,     1'b1, PC_REJECT);
      6'd1:  u = mk(ACT_DONE,    SRC_CONST,   8'h00,     1'b1, PC_REJECT);
      6'd2:  u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, PC_DONE);
      6'd3:  u = mk(ACT_SEND,    SRC_DATA,    8'h00,     1'b1, PC_REJECT);
      6'd4:  u = mk(ACT_SEND,    SRC_DATA,    8'h00,     1'b0, PC_TAIL);
      // release, write disable, poll
      6'd5:  u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd6);
      6'd6:  u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd7);
      6'd7:  u = mk(ACT_SEND,    SRC_CONST,   OP_WRDI,   1'b0, 6'd8);
      6'd8:  u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd9);
      6'd9:  u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd10);
      6'd10: u = mk(ACT_SEND,    SRC_CONST,   OP_RDSR1,  1'b0, 6'd11);
      6'd11: u = mk(ACT_RECV,    SRC_CONST,   8'h00,     1'b1, PC_REJECT);
      // read data
      6'd12: u = mk(ACT_DELIVER, SRC_DATA,    8'h00,     1'b0, 6'd13);
      6'd13: u = mk(ACT_RECV,    SRC_CONST,   8'h00,     1'b1, PC_REJECT);
      6'd14: u = mk(ACT_DELIVER, SRC_DATA,    8'h00,     1'b0, PC_REL_DONE);
      // page program header
      6'd15: u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd16);
      6'd16: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd17);
      6'd17: u = mk(ACT_SEND,    SRC_CONST,   OP_WREN,   1'b0, 6'd18);
      6'd18: u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd19);
      6'd19: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd20);
      6'd20: u = mk(ACT_SEND,    SRC_CONST,   OP_PROG,   1'b0, 6'd21);
      6'd21: u = mk(ACT_SEND,    SRC_ADDR_HI, 8'h00,     1'b0, 6'd22);
      6'd22: u = mk(ACT_SEND,    SRC_ADDR_MD, 8'h00,     1'b0, 6'd23);
      6'd23: u = mk(ACT_SEND,    SRC_ADDR_LO, 8'h00,     1'b1, PC_REJECT);
      // read header, then first receive
      6'd24: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd25);
      6'd25: u = mk(ACT_SEND,    SRC_CONST,   OP_READ,   1'b0, 6'd26);
      6'd26: u = mk(ACT_SEND,    SRC_ADDR_HI, 8'h00,     1'b0, 6'd27);
      6'd27: u = mk(ACT_SEND,    SRC_ADDR_MD, 8'h00,     1'b0, 6'd28);
      6'd28: u = mk(ACT_SEND,    SRC_ADDR_LO, 8'h00,     1'b0, 6'd29);
      6'd29: u = mk(ACT_RECV,    SRC_CONST,   8'h00,     1'b1, PC_REJECT);
      // empty read: header, release, done
      6'd30: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd31);
      6'd31: u = mk(ACT_SEND,    SRC_CONST,   OP_READ,   1'b0, 6'd32);
      6'd32: u = mk(ACT_SEND,    SRC_ADDR_HI, 8'h00,     1'b0, 6'd33);
      6'd33: u = mk(ACT_SEND,    SRC_ADDR_MD, 8'h00,     1'b0, 6'd34);
      6'd34: u = mk(ACT_SEND,    SRC_ADDR_LO, 8'h00,     1'b0, PC_REL_DONE);
      // sector erase
      6'd35: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd36);
      6'd36: u = mk(ACT_SEND,    SRC_CONST,   OP_WREN,   1'b0, 6'd37);
      6'd37: u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd38);
      6'd38: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd39);
      6'd39: u = mk(ACT_SEND,    SRC_CONST,   OP_SECTOR, 1'b0, 6'd40);
      6'd40: u = mk(ACT_SEND,    SRC_ADDR_HI, 8'h00,     1'b0, 6'd41);
      6'd41: u = mk(ACT_SEND,    SRC_ADDR_MD, 8'h00,     1'b0, 6'd42);
      6'd42: u = mk(ACT_SEND,    SRC_ADDR_LO, 8'h00,     1'b0, PC_TAIL);
      // chip erase
      6'd43: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd44);
      6'd44: u = mk(ACT_SEND,    SRC_CONST,   OP_WREN,   1'b0, 6'd45);
      6'd45: u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, 6'd46);
      6'd46: u = mk(ACT_SELECT,  SRC_CONST,   8'h00,     1'b0, 6'd47);
      6'd47: u = mk(ACT_SEND,    SRC_CONST,   OP_CHIP,   1'b0, 6'd48);
      6'd48: u = mk(ACT_RELEASE, SRC_CONST,   8'h00,     1'b0, PC_WRDI);
      default: u = mk(ACT_REJECT, SRC_CONST,  8'h00,     1'b1, PC_REJECT);
    endcase
    return u;
  endfunction

endpackage

// ===== design/sfcs_req_if.sv =====
// Request channel: host requests, write data and bytes received from the flash.
`timescale 1ns / 1ps

interface sfcs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [23:0] addr;
  logic [24:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, func, addr, length, data_byte, input ready);
  modport sink   (input valid, func, addr, length, data_byte, output ready);
endinterface

// ===== design/sfcs_res_if.sv =====
// Result channel: link actions toward the serial interface.
`timescale 1ns / 1ps

interface sfcs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] link_byte;
  logic       last;

  modport source (output valid, action, link_byte, last, input ready);
  modport sink   (input valid, action, link_byte, last, output ready);
endinterface

// ===== design/sfcs_front.sv =====
// Front end: accepts requests, tracks the transfer phase and emits one job per request.
`timescale 1ns / 1ps

module sfcs_front #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           capacity_log2,
  sfcs_req_if.sink             req,
  input  logic                 q_full,
  output logic                 push,
  output sfcs_pkg::job_t       push_job
);
  import sfcs_pkg::*;

  localparam int PG_LOG  = $clog2(PAGE_BYTES);
  localparam int CHUNK_W = PG_LOG + 1;

  phase_t              phase, phase_next;
  logic [ADDR_W-1:0]   next_address, next_address_next;
  logic [LEN_W-1:0]    bytes_remaining, bytes_remaining_next;
  logic [CHUNK_W-1:0]  chunk_left, chunk_left_next;

  logic [CAP_W-1:0]    cap_l;
  logic [ADDR_W-1:0]   mask;
  logic [ADDR_W-1:0]   ch_addr;
  logic [LEN_W-1:0]    ch_rem;
  logic [LEN_W-1:0]    page_room;
  logic [LEN_W-1:0]    cap_room;
  logic [LEN_W-1:0]    ch_size;
  logic [LEN_W-1:0]    br_dec;
  logic [CHUNK_W-1:0]  cl_dec;
  logic                accept;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign push      = accept;

  // Capacity mask, clamped to the supported range
  always_comb begin
    if (capacity_log2 < CAP_MIN) begin
      cap_l = CAP_MIN;
    end else if (capacity_log2 > CAP_MAX) begin
      cap_l = CAP_MAX;
    end else begin
      cap_l = capacity_log2;
    end
    mask = {ADDR_W{1'b1}} >> (CAP_MAX - cap_l);
  end

  // Size of the next page program: page end, remaining bytes, capacity wrap
  always_comb begin
    if (phase == PH_IDLE) begin
      ch_addr = req.addr & mask;
      ch_rem  = req.length;
    end else begin
      ch_addr = next_address & mask;
      ch_rem  = bytes_remaining;
    end
    page_room = LEN_W'(PAGE_BYTES) - LEN_W'(ch_addr[PG_LOG-1:0]);
    cap_room  = ({1'b0, mask} + LEN_W'(1)) - {1'b0, ch_addr};
    ch_size   = page_room;
    if (ch_size > ch_rem) begin
      ch_size = ch_rem;
    end
    if (ch_size > cap_room) begin
      ch_size = cap_room;
    end
  end

  assign br_dec = (bytes_remaining != '0) ? bytes_remaining - LEN_W'(1) : bytes_remaining;
  assign cl_dec = (chunk_left != '0) ? chunk_left - CHUNK_W'(1) : chunk_left;

  // Request classification and state update
  always_comb begin
    phase_next           = phase;
    next_address_next    = next_address;
    bytes_remaining_next = bytes_remaining;
    chunk_left_next      = chunk_left;
    push_job.pc          = PC_REJECT;
    push_job.addr        = req.addr & mask;
    push_job.data        = req.data_byte;
    unique case (phase)
      PH_IDLE: begin
        unique case (req.func)
          FN_WRITE: begin
            if (req.length == '0) begin
              push_job.pc = PC_DONE;
            end else begin
              next_address_next    = ch_addr;
              bytes_remaining_next = req.length;
              chunk_left_next      = ch_size[CHUNK_W-1:0];
              push_job.pc          = PC_CHUNK;
              push_job.addr        = ch_addr;
              phase_next           = PH_WDATA;
            end
          end
          FN_READ: begin
            if (req.length == '0) begin
              push_job.pc = PC_READ_EMPTY;
            end else begin
              bytes_remaining_next = req.length;
              push_job.pc          = PC_READ;
              phase_next           = PH_READ;
            end
          end
          FN_SECTOR: begin
            bytes_remaining_next = '0;
            push_job.pc          = PC_SECTOR;
            phase_next           = PH_POLL;
          end
          FN_CHIP: begin
            bytes_remaining_next = '0;
            push_job.pc          = PC_CHIP;
            phase_next           = PH_POLL;
          end
          default: push_job.pc = PC_REJECT;
        endcase
      end
      PH_WDATA: begin
        if (req.func == FN_DATA) begin
          bytes_remaining_next = br_dec;
          chunk_left_next      = cl_dec;
          next_address_next    = (next_address + ADDR_W'(1)) & mask;
          if (cl_dec == '0) begin
            push_job.pc = PC_WDATA_END;
            phase_next  = PH_POLL;
          end else begin
            push_job.pc = PC_WDATA_MID;
          end
        end
      end
      PH_POLL: begin
        if (req.func == FN_RX) begin
          if (req.data_byte[0]) begin
            push_job.pc = PC_POLL_AGAIN;
          end else if (bytes_remaining != '0) begin
            next_address_next = ch_addr;
            chunk_left_next   = ch_size[CHUNK_W-1:0];
            push_job.pc       = PC_NEXT_CHUNK;
            push_job.addr     = ch_addr;
            phase_next        = PH_WDATA;
          end else begin
            push_job.pc = PC_REL_DONE;
            phase_next  = PH_IDLE;
          end
        end
      end
      PH_READ: begin
        if (req.func == FN_RX) begin
          bytes_remaining_next = br_dec;
          if (br_dec != '0) begin
            push_job.pc = PC_RD_MID;
          end else begin
            push_job.pc = PC_RD_END;
            phase_next  = PH_IDLE;
          end
        end
      end
      default: push_job.pc = PC_REJECT;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      next_address    <= '0;
      bytes_remaining <= '0;
      chunk_left      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      next_address    <= next_address_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_left      <= chunk_left_next;
    end
  end

  // A page program in progress always has bytes left in its chunk
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WDATA |-> chunk_left != '0)
    else $error("write data phase with empty chunk");

  // Entering the write data phase always queues a program header
  a_header_on_wdata: assert property (@(posedge clk) disable iff (rst)
    accept && phase != PH_WDATA && phase_next == PH_WDATA
      |-> (push_job.pc == PC_CHUNK || push_job.pc == PC_NEXT_CHUNK))
    else $error("write data phase entered without program header");

endmodule

// ===== design/sfcs_queue.sv =====
// Short job queue between the front end and the sequencer.
`timescale 1ns / 1ps

module sfcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfcs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sfcs_pkg::job_t head_job
);
  import sfcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("job queue underflow");

endmodule

// ===== design/sfcs_back.sv =====
// Sequencer: walks the sequence ROM for each queued job, one link action per cycle while the result side is ready.
`timescale 1ns / 1ps

module sfcs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sfcs_pkg::job_t head_job,
  output logic           pop,
  sfcs_res_if.source     res
);
  import sfcs_pkg::*;

  logic       started;
  pc_t        pc;
  pc_t        cur_pc;
  uop_t       u;
  logic       adv;
  logic       out_valid;
  logic [2:0] out_action;
  logic [7:0] out_byte;
  logic       out_last;
  logic [7:0] sel_byte;

  assign cur_pc = started ? pc : head_job.pc;
  assign u      = uop_rom(cur_pc);
  assign adv    = head_valid && (!out_valid || res.ready);
  assign pop    = adv && u.last;

  // Link byte selection
  always_comb begin
    unique case (u.src)
      SRC_ADDR_HI: sel_byte = head_job.addr[23:16];
      SRC_ADDR_MD: sel_byte = head_job.addr[15:8];
      SRC_ADDR_LO: sel_byte = head_job.addr[7:0];
      SRC_DATA:    sel_byte = head_job.data;
      default:     sel_byte = u.cbyte;
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pc      <= PC_REJECT;
    end else if (adv) begin
      started <= !u.last;
      pc      <= u.next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_action <= u.action;
      out_byte   <= sel_byte;
      out_last   <= u.last;
    end
  end

  assign res.valid     = out_valid;
  assign res.action    = out_action;
  assign res.link_byte = out_byte;
  assign res.last      = out_last;

  // A sequence in progress keeps its job at the queue head
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    started |-> head_valid)
    else $error("sequence running without a job");

endmodule

// ===== design/spi_nor_flash_command_sequencer_top.sv =====
// Top level of the serial NOR flash command sequencer.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   func, addr, length, data_byte
//  res      out  valid/ready   action, link_byte, last
//  cfg      in   cfg_we        cfg_data = capacity_log2
//
// A request is taken every cycle while the job queue has room; it yields
// one to fifteen results, emitted by the sequencer at one per cycle while
// the link side is ready.
// The result register and the job queue let both sides stall on their own.
// Reset (rst, synchronous) empties the queue and the result register,
// puts the phase to idle and sets capacity_log2 to 24.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_top #(
  parameter int PAGE_BYTES  = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  sfcs_req_if.sink   req,
  sfcs_res_if.source res
);
  import sfcs_pkg::*;

  logic [CAP_W-1:0] capacity_log2;
  logic             push, full, pop, head_valid;
  job_t             push_job, head_job;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_log2 <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_log2 <= cfg_data;
    end
  end

  sfcs_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .capacity_log2 (capacity_log2),
    .req           (req),
    .q_full        (full),
    .push          (push),
    .push_job      (push_job)
  );

  sfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res        (res)
  );

endmodule

// ===== tb/sv/sfcs_link_checker.sv =====
// Link checker: follows both channels, predicts the link steps of every request and compares.
`timescale 1ns / 1ps

module sfcs_link_checker
  import sfcs_pkg::*;
#(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  sfcs_req_if         req,
  sfcs_res_if         res,
  output phase_t      flash_phase,
  output int unsigned outstanding,
  output int unsigned mismatch_count
);

  localparam int BUSY_BIT = 0;

  typedef struct packed {
    act_t       action;
    logic [7:0] link_byte;
    logic       last;
  } link_step_t;

  // Link steps predicted but not yet seen on the result channel
  link_step_t steps_due[$];

  // Shadow of the sequencer state
  logic [CAP_W-1:0]  cap_log2;
  logic [ADDR_W-1:0] prog_addr;
  logic [LEN_W-1:0]  bytes_left;
  int unsigned       chunk_left;

  // Address mask for the current capacity, clamped to the supported range
  function automatic logic [ADDR_W-1:0] addr_mask();
    int unsigned lg;
    lg = cap_log2;
    if (lg < CAP_MIN) lg = CAP_MIN;
    if (lg > CAP_MAX) lg = CAP_MAX;
    return 24'((32'd1 << lg) - 32'd1);
  endfunction

  task automatic emit_step(input act_t act, input logic [7:0] link_byte);
    link_step_t s;
    s.action    = act;
    s.link_byte = link_byte;
    s.last      = 1'b0;
    steps_due.push_back(s);
  endtask

  // A one-byte command framed by its own select and release
  task automatic emit_alone(input logic [7:0] op);
    emit_step(ACT_SELECT, 8'h00);
    emit_step(ACT_SEND, op);
    emit_step(ACT_RELEASE, 8'h00);
  endtask

  task automatic emit_address(input logic [ADDR_W-1:0] a);
    emit_step(ACT_SEND, a[23:16]);
    emit_step(ACT_SEND, a[15:8]);
    emit_step(ACT_SEND, a[7:0]);
  endtask

  task automatic start_status_poll();
    emit_step(ACT_SELECT, 8'h00);
    emit_step(ACT_SEND, OP_RDSR1);
    emit_step(ACT_RECV, 8'h00);
    flash_phase = PH_POLL;
  endtask

  // Chunk ends at the page end, at the capacity end, or with the data
  task automatic open_page_program();
    logic [ADDR_W-1:0] mask;
    int unsigned size;
    int unsigned room;
    mask = addr_mask();
    prog_addr = prog_addr & mask;
    size = PAGE_BYTES - (32'(prog_addr) % PAGE_BYTES);
    if (size > 32'(bytes_left)) size = 32'(bytes_left);
    room = 32'(mask) + 32'd1 - 32'(prog_addr);
    if (size > room) size = room;
    chunk_left = size;
    emit_alone(OP_WREN);
    emit_step(ACT_SELECT, 8'h00);
    emit_step(ACT_SEND, OP_PROG);
    emit_address(prog_addr);
    flash_phase = PH_WDATA;
  endtask

  // Link steps caused by one request, with last set on the final one
  task automatic predict_link_steps(input logic [2:0] f, input logic [ADDR_W-1:0] a,
                                    input logic [LEN_W-1:0] n, input logic [7:0] b);
    logic [ADDR_W-1:0] mask;
    link_step_t tail;
    mask = addr_mask();
    if (flash_phase == PH_IDLE && f == FN_WRITE) begin
      if (n == '0) begin
        emit_step(ACT_DONE, 8'h00);
      end else begin
        prog_addr  = a & mask;
        bytes_left = n;
        open_page_program();
      end
    end else if (flash_phase == PH_IDLE && f == FN_READ) begin
      emit_step(ACT_SELECT, 8'h00);
      emit_step(ACT_SEND, OP_READ);
      emit_address(a & mask);
      if (n == '0) begin
        emit_step(ACT_RELEASE, 8'h00);
        emit_step(ACT_DONE, 8'h00);
      end else begin
        bytes_left = n;
        emit_step(ACT_RECV, 8'h00);
        flash_phase = PH_READ;
      end
    end else if (flash_phase == PH_IDLE && f == FN_SECTOR) begin
      bytes_left = '0;
      emit_alone(OP_WREN);
      emit_step(ACT_SELECT, 8'h00);
      emit_step(ACT_SEND, OP_SECTOR);
      emit_address(a & mask);
      emit_step(ACT_RELEASE, 8'h00);
      emit_alone(OP_WRDI);
      start_status_poll();
    end else if (flash_phase == PH_IDLE && f == FN_CHIP) begin
      bytes_left = '0;
      emit_alone(OP_WREN);
      emit_alone(OP_CHIP);
      emit_alone(OP_WRDI);
      start_status_poll();
    end else if (flash_phase == PH_WDATA && f == FN_DATA) begin
      emit_step(ACT_SEND, b);
      if (bytes_left != '0) bytes_left = bytes_left - 25'd1;
      if (chunk_left != 0) chunk_left = chunk_left - 1;
      prog_addr = (prog_addr + 24'd1) & mask;
      if (chunk_left == 0) begin
        emit_step(ACT_RELEASE, 8'h00);
        emit_alone(OP_WRDI);
        start_status_poll();
      end
    end else if (flash_phase == PH_POLL && f == FN_RX) begin
      emit_step(ACT_RELEASE, 8'h00);
      if (b[BUSY_BIT]) begin
        start_status_poll();
      end else if (bytes_left != '0) begin
        open_page_program();
      end else begin
        emit_step(ACT_DONE, 8'h00);
        flash_phase = PH_IDLE;
      end
    end else if (flash_phase == PH_READ && f == FN_RX) begin
      emit_step(ACT_DELIVER, b);
      if (bytes_left != '0) bytes_left = bytes_left - 25'd1;
      if (bytes_left != '0) begin
        emit_step(ACT_RECV, 8'h00);
      end else begin
        emit_step(ACT_RELEASE, 8'h00);
        emit_step(ACT_DONE, 8'h00);
        flash_phase = PH_IDLE;
      end
    end else begin
      emit_step(ACT_REJECT, 8'h00);
    end
    tail = steps_due.pop_back();
    tail.last = 1'b1;
    steps_due.push_back(tail);
  endtask

  // Config, then prediction, then comparison of the accepted link step
  always @(posedge clk) begin
    link_step_t want;
    if (rst) begin
      cap_log2       = CAP_RESET;
      flash_phase    = PH_IDLE;
      prog_addr      = '0;
      bytes_left     = '0;
      chunk_left     = 0;
      mismatch_count = 0;
      steps_due.delete();
    end else begin
      if (cfg_we) cap_log2 = cfg_data;
      if (req.valid && req.ready) begin
        predict_link_steps(req.func, req.addr, req.length, req.data_byte);
      end
      if (res.valid && res.ready) begin
        if (steps_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected link step: action %0d byte %02h last %0b",
                     $realtime, res.action, res.link_byte, res.last);
          end
        end else begin
          want = steps_due.pop_front();
          if (res.action !== want.action || res.link_byte !== want.link_byte ||
              res.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: link step mismatch: expected action %0d byte %02h last %0b",
                       $realtime, want.action, want.link_byte, want.last);
              $display("%0t:                      got action %0d byte %02h last %0b",
                       $realtime, res.action, res.link_byte, res.last);
            end
          end
        end
      end
    end
    outstanding = steps_due.size();
  end

endmodule

// ===== tb/sv/spi_nor_flash_command_sequencer_top_tb.sv =====
// Testbench top: drives requests and capacity settings, stalls the link side, gives the verdict.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_top_tb;
  import sfcs_pkg::*;

  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam int SEGMENTS         = 5;
  localparam int SEGMENT_REQUESTS = 40;
  localparam int QUIET_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 20;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       cfg_we   = 1'b0;
  logic [4:0] cfg_data = CAP_RESET;

  phase_t      flash_phase;
  int unsigned outstanding;
  int unsigned mismatch_count;
  int unsigned quiet_cycles = 0;

  sfcs_req_if req ();
  sfcs_res_if res ();

  always #5 clk = ~clk;

  spi_nor_flash_command_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .res      (res)
  );

  sfcs_link_checker link_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .req            (req),
    .res            (res),
    .flash_phase    (flash_phase),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  // Watchdog on cycles where neither channel moves anything
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Link-side back-pressure: long ready runs, short stalls, a few long ones
  initial begin : link_stall
    int unsigned run;
    res.ready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run != 0) begin
        run--;
      end else if ($urandom_range(99) < 60) begin
        res.ready <= 1'b1;
        run = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(30, 1);
      end else begin
        res.ready <= 1'b0;
        run = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(3, 1);
      end
    end
  end

  // Ends at a falling edge; request valid is low during any gap
  task automatic idle_gap(input bit calm);
    int unsigned roll;
    int unsigned gap;
    @(negedge clk);
    roll = $urandom_range(99);
    if (calm || roll < 65) gap = 0;
    else if (roll < 93) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 8);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Called at a falling edge; returns at the edge that takes the request
  task automatic issue(input logic [2:0] f, input logic [23:0] a,
                       input logic [24:0] n, input logic [7:0] b);
    req.valid     <= 1'b1;
    req.func      <= f;
    req.addr      <= a;
    req.length    <= n;
    req.data_byte <= b;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic request(input logic [2:0] f, input logic [23:0] a,
                         input logic [24:0] n, input logic [7:0] b);
    idle_gap(1'b0);
    issue(f, a, n, b);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Start addresses: often near a page end or the top of the capacity
  function automatic logic [23:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return {16'($urandom), 4'hF, 4'($urandom)};
    if (roll < 45) return 24'hFFFFFF - 24'($urandom_range(15));
    return 24'($urandom);
  endfunction

  initial begin
    logic [2:0]  f;
    logic [23:0] a;
    logic [24:0] n;
    logic [7:0]  b;
    logic [4:0]  cap_plan [SEGMENTS];
    int unsigned roll;
    int unsigned k;
    bit          seg_done;

    req.valid     = 1'b0;
    req.func      = FN_WRITE;
    req.addr      = '0;
    req.length    = '0;
    req.data_byte = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty write and empty read
    request(FN_WRITE, 24'h000000, 25'd0, 8'h00);
    request(FN_READ, 24'hFFFFFF, 25'd0, 8'hFF);
    // Program across the top of the address space: two bytes, wrap, one byte
    request(FN_WRITE, 24'hFFFFFE, 25'd3, 8'h00);
    request(FN_DATA, 24'h000000, 25'd0, 8'hFF);
    request(FN_DATA, 24'hFFFFFF, 25'h1FFFFFF, 8'h00);
    request(FN_RX, 24'h000000, 25'd0, 8'h01);
    request(FN_RX, 24'h000000, 25'd0, 8'hFE);
    request(FN_DATA, 24'h000000, 25'd0, 8'hA5);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Two-byte read
    request(FN_READ, 24'h123456, 25'd2, 8'h00);
    request(FN_RX, 24'h000000, 25'd0, 8'hFF);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Sector erase at an unaligned address, then chip erase
    request(FN_SECTOR, 24'hABCDEF, 25'd0, 8'h00);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);
    request(FN_CHIP, 24'h000000, 25'd0, 8'h00);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Unused function codes
    request(FN_UNUSED_LO, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
    request(FN_UNUSED_HI, 24'h000000, 25'd0, 8'h00);
    // Capacity shrinks while a program is open; the next byte wraps to zero
    request(FN_WRITE, 24'h0012FE, 25'd4, 8'h00);
    request(FN_DATA, 24'h000000, 25'd0, 8'h11);
    request(FN_WRITE, 24'h000000, 25'd1, 8'h00);
    set_capacity(CAP_MIN);
    request(FN_DATA, 24'h000000, 25'd0, 8'h22);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);
    request(FN_DATA, 24'h000000, 25'd0, 8'h33);
    request(FN_DATA, 24'h000000, 25'd0, 8'h44);
    request(FN_RX, 24'h000000, 25'd0, 8'h00);

    // Random traffic, one capacity per segment, each segment ends idle
    cap_plan = '{5'd31, 5'd0, CAP_MIN, 5'd16, CAP_MAX};
    cap_plan[3] = 5'($urandom_range(23, 9));
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_capacity(cap_plan[seg]);
      k = 0;
      seg_done = 1'b0;
      while (!seg_done) begin
        idle_gap(k < 12);
        if (k >= SEGMENT_REQUESTS && flash_phase == PH_IDLE) begin
          req.valid <= 1'b0;
          seg_done = 1'b1;
        end else begin
          roll = $urandom_range(99);
          a = 24'($urandom);
          n = 25'($urandom);
          b = 8'($urandom);
          case (flash_phase)
            PH_IDLE: begin
              if (roll < 8) begin
                case ($urandom_range(3))
                  0: f = FN_DATA;
                  1: f = FN_RX;
                  2: f = FN_UNUSED_LO;
                  default: f = FN_UNUSED_HI;
                endcase
              end else if (roll < 50) begin
                f = FN_WRITE;
                a = pick_address();
                roll = $urandom_range(99);
                if (roll < 8) n = '0;
                else if (roll < 80) n = 25'($urandom_range(8, 1));
                else n = 25'($urandom_range(40, 9));
              end else if (roll < 78) begin
                f = FN_READ;
                a = pick_address();
                n = 25'($urandom_range(6));
              end else if (roll < 90) begin
                f = FN_SECTOR;
              end else begin
                f = FN_CHIP;
              end
            end
            PH_WDATA: begin
              f = FN_DATA;
              if (roll >= 93) begin
                f = 3'($urandom);
                if (f == FN_DATA) f = FN_UNUSED_HI;
              end
            end
            PH_POLL: begin
              f = FN_RX;
              b[0] = ($urandom_range(99) < 35);
              if (roll >= 92) begin
                f = 3'($urandom);
                if (f == FN_RX) f = FN_UNUSED_LO;
              end
            end
            default: begin
              f = FN_RX;
              if (roll >= 92) begin
                f = 3'($urandom);
                if (f == FN_RX) f = FN_UNUSED_LO;
              end
            end
          endcase
          issue(f, a, n, b);
          k++;
          // Now and then hold off until the link side has caught up
          if ($urandom_range(49) == 0) drain_results();
        end
      end
    end

    // Read of 0x1000000 bytes, below the largest length; left open at the end of the run
    request(FN_READ, 24'($urandom), 25'h1000000, 8'h00);
    repeat (20) request(FN_RX, 24'($urandom), 25'($urandom), 8'($urandom));
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
